### src/gasp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid A* path search package
// Operation codes, register indexes, fixed field widths and small helpers.
// ----------------------------------------------------------------------------
package gasp_pkg;

    typedef logic [1:0] t_op;

    localparam t_op OP_LOAD      = 2'd0;
    localparam t_op OP_SEARCH    = 2'd1;
    localparam t_op OP_READ_PATH = 2'd2;
    localparam t_op OP_READ_VIS  = 2'd3;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 6;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_ROWS = 1'b0;
    localparam t_cfg_idx REG_COLS = 1'b1;

    // Width of a row or column value wide enough for every grid size.
    localparam int DIM_W = 9;

    typedef logic [DIM_W-1:0] t_dim;

    localparam int POS_W   = 5;
    localparam int WIN_W   = 4;
    localparam int INDEX_W = 10;
    localparam int COST_W  = 14;
    localparam int COUNT_W = 11;

    function automatic t_dim absdiff(input t_dim a, input t_dim b);
        absdiff = (a > b) ? (a - b) : (b - a);
    endfunction

    // A zero setting acts as one row; a setting above the grid acts as the grid.
    function automatic t_dim eff_dim(input logic [CFG_W-1:0] v, input t_dim mx);
        t_dim ve;
        ve = t_dim'(v);
        if (ve == '0) begin
            eff_dim = t_dim'(1);
        end else if (ve > mx) begin
            eff_dim = mx;
        end else begin
            eff_dim = ve;
        end
    endfunction

endpackage

### src/gasp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid A* simple dual-port RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module gasp_ram #(
    parameter int W  = 8,
    parameter int D  = 16,
    parameter int AW = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wa,
    input  logic [W-1:0]  i_wd,
    input  logic          i_re,
    input  logic [AW-1:0] i_ra,
    output logic [W-1:0]  o_rd
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            o_rd <= r_mem[i_ra];
        end
    end

endmodule

### src/grid_astar_path_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid A* path search
// Four-neighbour A* over a weighted grid with walls, Manhattan heuristic.
// ----------------------------------------------------------------------------
// Every transfer on start (while busy is low) yields exactly one result, shown
// for one cycle with o_valid; the receiver cannot stall, so it must take it.
// After reset the block is busy while a clearing pass zeroes the cell weights
// and walls at every address. A search first sweeps the whole per-cell search
// memory, then for each popped cell takes the heap top and sifts the last entry
// down, reads the cell's search entry and checks its four neighbours, pushing
// each improved one onto the heap; pushes and sift-downs walk one heap level at
// a time through the single read port of the heap memory. The path trace-back
// then reads the grid and search memories for each path cell.
// ----------------------------------------------------------------------------
module grid_astar_path_search_top #(
    parameter int GRID_ROWS   = 32,
    parameter int GRID_COLS   = 32,
    parameter int WEIGHT_BITS = 4,
    parameter int HEAP_DEPTH  = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cfg_we,
    input  logic [gasp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gasp_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic [1:0]                      i_op,
    input  logic [gasp_pkg::POS_W-1:0]      i_row,
    input  logic [gasp_pkg::POS_W-1:0]      i_col,
    input  logic [gasp_pkg::WIN_W-1:0]      i_weight,
    input  logic                            i_wall,
    input  logic [gasp_pkg::POS_W-1:0]      i_goal_row,
    input  logic [gasp_pkg::POS_W-1:0]      i_goal_col,
    input  logic [gasp_pkg::INDEX_W-1:0]    i_index,
    output logic                            o_valid,
    output logic                            o_found,
    output logic [gasp_pkg::COST_W-1:0]     o_total_cost,
    output logic [gasp_pkg::COUNT_W-1:0]    o_path_length,
    output logic [gasp_pkg::COUNT_W-1:0]    o_visited_count,
    output logic [gasp_pkg::POS_W-1:0]      o_cell_row,
    output logic [gasp_pkg::POS_W-1:0]      o_cell_col,
    output logic                            o_heap_overflow
);

    localparam int DW    = gasp_pkg::DIM_W;
    localparam int RB    = $clog2(GRID_ROWS);
    localparam int CB    = $clog2(GRID_COLS);
    localparam int CA    = RB + CB;
    localparam int CELLS = GRID_ROWS * GRID_COLS;
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int GB    = WEIGHT_BITS + $clog2(CELLS) + 1;
    localparam int FW    = ((GB > DW + 1) ? GB : DW + 1) + 1;
    localparam int KW    = FW + GB + CA;
    localparam int HA    = $clog2(HEAP_DEPTH);
    localparam int HS    = $clog2(HEAP_DEPTH + 1);
    localparam int IW    = (CNT_W > gasp_pkg::INDEX_W) ? CNT_W : gasp_pkg::INDEX_W;
    localparam int GW    = WEIGHT_BITS + 1;
    localparam int SW    = GB + CA + 2;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_RSTCLR  = 5'd1;
    localparam logic [4:0] S_CLR     = 5'd2;
    localparam logic [4:0] S_INIT    = 5'd3;
    localparam logic [4:0] S_POP0    = 5'd4;
    localparam logic [4:0] S_POP1    = 5'd5;
    localparam logic [4:0] S_POP2    = 5'd6;
    localparam logic [4:0] S_SIFT    = 5'd7;
    localparam logic [4:0] S_SIFT1   = 5'd8;
    localparam logic [4:0] S_SIFT2   = 5'd9;
    localparam logic [4:0] S_SIFT3   = 5'd10;
    localparam logic [4:0] S_SIFTEND = 5'd11;
    localparam logic [4:0] S_CUR0    = 5'd12;
    localparam logic [4:0] S_CUR1    = 5'd13;
    localparam logic [4:0] S_NB0     = 5'd14;
    localparam logic [4:0] S_NB1     = 5'd15;
    localparam logic [4:0] S_NBNEXT  = 5'd16;
    localparam logic [4:0] S_PUSH0   = 5'd17;
    localparam logic [4:0] S_PUSH1   = 5'd18;
    localparam logic [4:0] S_PUSH2   = 5'd19;
    localparam logic [4:0] S_TR0     = 5'd20;
    localparam logic [4:0] S_TR1     = 5'd21;
    localparam logic [4:0] S_RD      = 5'd22;
    localparam logic [4:0] S_FIN     = 5'd23;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // Control registers.
    logic [4:0]                   r_state, n_state;
    logic [4:0]                   r_ret, n_ret;
    logic [CA-1:0]                r_cnt, n_cnt;
    logic [gasp_pkg::CFG_W-1:0]   r_rows, n_rows;
    logic [gasp_pkg::CFG_W-1:0]   r_cols, n_cols;
    logic                         r_valid, n_valid;
    logic                         r_found, n_found;
    logic                         r_ovf, n_ovf;
    logic [GB-1:0]                r_cost, n_cost;
    logic [CNT_W-1:0]             r_len, n_len;
    logic [CNT_W-1:0]             r_vis, n_vis;
    logic [HS-1:0]                r_hsize, n_hsize;

    // Payload registers.
    logic [DW-1:0]                r_nrows, n_nrows;
    logic [DW-1:0]                r_ncols, n_ncols;
    logic [DW-1:0]                r_goal_r, n_goal_r;
    logic [DW-1:0]                r_goal_c, n_goal_c;
    logic [KW-1:0]                r_item, n_item;
    logic [KW-1:0]                r_top, n_top;
    logic [KW-1:0]                r_last, n_last;
    logic [KW-1:0]                r_hl, n_hl;
    logic [KW-1:0]                r_hs, n_hs;
    logic [HA-1:0]                r_hi, n_hi;
    logic [HA-1:0]                r_s, n_s;
    logic [1:0]                   r_dir, n_dir;
    logic [CA-1:0]                r_k, n_k;
    logic                         r_knone, n_knone;
    logic [CNT_W-1:0]             r_n, n_n;
    logic                         r_rdhit, n_rdhit;
    logic                         r_rdpath, n_rdpath;
    logic [gasp_pkg::POS_W-1:0]   r_crow, n_crow;
    logic [gasp_pkg::POS_W-1:0]   r_ccol, n_ccol;

    // Memory ports.
    logic          grid_we, grid_re;
    logic [CA-1:0] grid_wa, grid_ra;
    logic [GW-1:0] grid_wd, grid_rd;
    logic          srch_we, srch_re;
    logic [CA-1:0] srch_wa, srch_ra;
    logic [SW-1:0] srch_wd, srch_rd;
    logic          heap_we, heap_re;
    logic [HA-1:0] heap_wa, heap_ra;
    logic [KW-1:0] heap_wd, heap_rd;
    logic          vis_we, vis_re;
    logic [CA-1:0] vis_wa, vis_ra;
    logic [CA-1:0] vis_rd;
    logic          path_we, path_re;
    logic [CA-1:0] path_wa, path_ra;
    logic [CA-1:0] path_rd;

    // Datapath terms.
    logic                accept;
    logic [DW-1:0]       in_row, in_col, in_grow, in_gcol;
    logic [DW-1:0]       acc_nrows, acc_ncols;
    logic [DW:0]         start_h;
    logic [DW-1:0]       cur_r, cur_c, nb_r, nb_c;
    logic                nb_ok;
    logic [CA-1:0]       nb_addr;
    logic [GB-1:0]       cur_g, ng;
    logic [DW:0]         nb_h;
    logic [FW-1:0]       nb_f;
    logic                g_wall;
    logic [WEIGHT_BITS-1:0] g_wt;
    logic [GB-1:0]       s_best;
    logic [CA-1:0]       s_parent;
    logic                s_pnone, s_closed;
    logic [HA:0]         sift_l;
    logic [HA+1:0]       sift_r;
    logic [IW-1:0]       idx_w, len_w, vis_w;
    logic [CA-1:0]       rd_cell;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign in_row  = DW'(i_row);
    assign in_col  = DW'(i_col);
    assign in_grow = DW'(i_goal_row);
    assign in_gcol = DW'(i_goal_col);
    assign acc_nrows = gasp_pkg::eff_dim(r_rows, DW'(GRID_ROWS));
    assign acc_ncols = gasp_pkg::eff_dim(r_cols, DW'(GRID_COLS));
    assign start_h = {1'b0, gasp_pkg::absdiff(in_row, in_grow)}
                   + {1'b0, gasp_pkg::absdiff(in_col, in_gcol)};

    assign cur_r = DW'(r_top[CA-1:CB]);
    assign cur_c = DW'(r_top[CB-1:0]);
    assign cur_g = r_top[CA +: GB];

    always_comb begin
        nb_r  = cur_r;
        nb_c  = cur_c;
        nb_ok = 1'b0;
        case (r_dir)
            DIR_UP: begin
                nb_r  = cur_r - DW'(1);
                nb_ok = (cur_r != '0);
            end
            DIR_DOWN: begin
                nb_r  = cur_r + DW'(1);
                nb_ok = (nb_r < r_nrows);
            end
            DIR_LEFT: begin
                nb_c  = cur_c - DW'(1);
                nb_ok = (cur_c != '0);
            end
            DIR_RIGHT: begin
                nb_c  = cur_c + DW'(1);
                nb_ok = (nb_c < r_ncols);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    assign nb_addr = {nb_r[RB-1:0], nb_c[CB-1:0]};
    assign g_wall  = grid_rd[WEIGHT_BITS];
    assign g_wt    = grid_rd[WEIGHT_BITS-1:0];
    assign ng      = cur_g + GB'(g_wt);
    assign nb_h    = {1'b0, gasp_pkg::absdiff(nb_r, r_goal_r)}
                   + {1'b0, gasp_pkg::absdiff(nb_c, r_goal_c)};
    assign nb_f    = FW'(ng) + FW'(nb_h);

    assign s_best   = srch_rd[GB-1:0];
    assign s_parent = srch_rd[GB +: CA];
    assign s_pnone  = srch_rd[GB + CA];
    assign s_closed = srch_rd[GB + CA + 1];

    assign sift_l = {r_hi, 1'b1};
    assign sift_r = (HA + 2)'(sift_l) + (HA + 2)'(1);

    assign idx_w = IW'(i_index);
    assign len_w = IW'(r_len);
    assign vis_w = IW'(r_vis);
    assign rd_cell = r_rdpath ? path_rd : vis_rd;

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_cnt    = r_cnt;
        n_rows   = r_rows;
        n_cols   = r_cols;
        n_valid  = 1'b0;
        n_found  = r_found;
        n_ovf    = r_ovf;
        n_cost   = r_cost;
        n_len    = r_len;
        n_vis    = r_vis;
        n_hsize  = r_hsize;
        n_nrows  = r_nrows;
        n_ncols  = r_ncols;
        n_goal_r = r_goal_r;
        n_goal_c = r_goal_c;
        n_item   = r_item;
        n_top    = r_top;
        n_last   = r_last;
        n_hl     = r_hl;
        n_hs     = r_hs;
        n_hi     = r_hi;
        n_s      = r_s;
        n_dir    = r_dir;
        n_k      = r_k;
        n_knone  = r_knone;
        n_n      = r_n;
        n_rdhit  = r_rdhit;
        n_rdpath = r_rdpath;
        n_crow   = r_crow;
        n_ccol   = r_ccol;

        grid_we = 1'b0; grid_wa = nb_addr; grid_wd = '0;
        grid_re = 1'b0; grid_ra = nb_addr;
        srch_we = 1'b0; srch_wa = nb_addr; srch_wd = '0;
        srch_re = 1'b0; srch_ra = nb_addr;
        heap_we = 1'b0; heap_wa = r_hi; heap_wd = r_item;
        heap_re = 1'b0; heap_ra = '0;
        vis_we  = 1'b0; vis_wa = CA'(r_vis); vis_re = 1'b0; vis_ra = CA'(idx_w);
        path_we = 1'b0; path_wa = CA'(r_n); path_re = 1'b0;
        path_ra = CA'(len_w - idx_w - IW'(1));

        if (i_cfg_we) begin
            case (i_cfg_idx)
                gasp_pkg::REG_ROWS: n_rows = i_cfg_wdata;
                gasp_pkg::REG_COLS: n_cols = i_cfg_wdata;
                default: n_rows = r_rows;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        gasp_pkg::OP_LOAD: begin
                            if (in_row < DW'(GRID_ROWS) && in_col < DW'(GRID_COLS)) begin
                                grid_we = 1'b1;
                                grid_wa = {in_row[RB-1:0], in_col[CB-1:0]};
                                grid_wd = {i_wall, WEIGHT_BITS'(i_weight)};
                            end
                            n_state = S_FIN;
                        end
                        gasp_pkg::OP_SEARCH: begin
                            n_found  = 1'b0;
                            n_ovf    = 1'b0;
                            n_cost   = '0;
                            n_len    = '0;
                            n_vis    = '0;
                            n_hsize  = '0;
                            n_cnt    = '0;
                            n_nrows  = acc_nrows;
                            n_ncols  = acc_ncols;
                            n_goal_r = in_grow;
                            n_goal_c = in_gcol;
                            n_item   = {FW'(start_h), GB'(0),
                                        in_row[RB-1:0], in_col[CB-1:0]};
                            // A start outside the grid in use ends the search empty.
                            if (in_row >= acc_nrows || in_col >= acc_ncols) begin
                                n_state = S_FIN;
                            end else begin
                                n_state = S_CLR;
                            end
                        end
                        gasp_pkg::OP_READ_PATH: begin
                            path_re  = 1'b1;
                            n_rdpath = 1'b1;
                            n_rdhit  = (idx_w < len_w) && (idx_w < IW'(CELLS));
                            n_state  = S_RD;
                        end
                        default: begin
                            vis_re   = 1'b1;
                            n_rdpath = 1'b0;
                            n_rdhit  = (idx_w < vis_w) && (idx_w < IW'(CELLS));
                            n_state  = S_RD;
                        end
                    endcase
                end
            end
            S_RSTCLR: begin
                grid_we = 1'b1;
                grid_wa = r_cnt;
                grid_wd = '0;
                n_cnt   = r_cnt + CA'(1);
                if (r_cnt == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_CLR: begin
                srch_we = 1'b1;
                srch_wa = r_cnt;
                srch_wd = {1'b0, 1'b1, CA'(0), {GB{1'b1}}};
                n_cnt   = r_cnt + CA'(1);
                if (r_cnt == '1) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                srch_we = 1'b1;
                srch_wa = r_item[CA-1:0];
                srch_wd = {1'b0, 1'b1, CA'(0), GB'(0)};
                n_ret   = S_POP0;
                n_state = S_PUSH0;
            end
            S_POP0: begin
                if (r_hsize == '0) begin
                    n_state = S_FIN;
                end else begin
                    heap_re = 1'b1;
                    heap_ra = '0;
                    n_state = S_POP1;
                end
            end
            S_POP1: begin
                n_top   = heap_rd;
                heap_re = 1'b1;
                heap_ra = HA'(r_hsize - HS'(1));
                n_state = S_POP2;
            end
            S_POP2: begin
                n_last  = heap_rd;
                n_hsize = r_hsize - HS'(1);
                n_hi    = '0;
                n_state = S_SIFT;
            end
            S_SIFT: begin
                if (sift_l >= r_hsize) begin
                    n_state = S_SIFTEND;
                end else begin
                    heap_re = 1'b1;
                    heap_ra = HA'(sift_l);
                    n_state = S_SIFT1;
                end
            end
            S_SIFT1: begin
                n_hl = heap_rd;
                if (sift_r < r_hsize) begin
                    heap_re = 1'b1;
                    heap_ra = HA'(sift_r);
                    n_state = S_SIFT2;
                end else begin
                    n_hs    = heap_rd;
                    n_s     = HA'(sift_l);
                    n_state = S_SIFT3;
                end
            end
            S_SIFT2: begin
                if (heap_rd < r_hl) begin
                    n_hs = heap_rd;
                    n_s  = HA'(sift_r);
                end else begin
                    n_hs = r_hl;
                    n_s  = HA'(sift_l);
                end
                n_state = S_SIFT3;
            end
            S_SIFT3: begin
                if (r_hs < r_last) begin
                    heap_we = 1'b1;
                    heap_wa = r_hi;
                    heap_wd = r_hs;
                    n_hi    = r_s;
                    n_state = S_SIFT;
                end else begin
                    n_state = S_SIFTEND;
                end
            end
            S_SIFTEND: begin
                if (r_hsize != '0) begin
                    heap_we = 1'b1;
                    heap_wa = r_hi;
                    heap_wd = r_last;
                end
                n_state = S_CUR0;
            end
            S_CUR0: begin
                srch_re = 1'b1;
                srch_ra = r_top[CA-1:0];
                n_state = S_CUR1;
            end
            S_CUR1: begin
                // Stale heap entries of closed cells are dropped here.
                if (s_closed) begin
                    n_state = S_POP0;
                end else begin
                    srch_we = 1'b1;
                    srch_wa = r_top[CA-1:0];
                    srch_wd = {1'b1, s_pnone, s_parent, s_best};
                    vis_we  = 1'b1;
                    vis_wa  = CA'(r_vis);
                    n_vis   = r_vis + CNT_W'(1);
                    if (cur_r == r_goal_r && cur_c == r_goal_c) begin
                        n_found = 1'b1;
                        n_k     = r_top[CA-1:0];
                        n_knone = 1'b0;
                        n_n     = '0;
                        n_state = S_TR0;
                    end else begin
                        n_dir   = DIR_UP;
                        n_state = S_NB0;
                    end
                end
            end
            S_NB0: begin
                if (nb_ok) begin
                    grid_re = 1'b1;
                    srch_re = 1'b1;
                    n_state = S_NB1;
                end else begin
                    n_state = S_NBNEXT;
                end
            end
            S_NB1: begin
                if (!g_wall && !s_closed && ng < s_best) begin
                    srch_we = 1'b1;
                    srch_wd = {1'b0, 1'b0, r_top[CA-1:0], ng};
                    n_item  = {nb_f, ng, nb_addr};
                    n_ret   = S_NBNEXT;
                    n_state = S_PUSH0;
                end else begin
                    n_state = S_NBNEXT;
                end
            end
            S_NBNEXT: begin
                if (r_dir == DIR_RIGHT) begin
                    n_state = S_POP0;
                end else begin
                    n_dir   = r_dir + 2'd1;
                    n_state = S_NB0;
                end
            end
            S_PUSH0: begin
                if (r_hsize >= HS'(HEAP_DEPTH)) begin
                    n_ovf   = 1'b1;
                    n_state = r_ret;
                end else begin
                    n_hi    = HA'(r_hsize);
                    n_hsize = r_hsize + HS'(1);
                    n_state = S_PUSH1;
                end
            end
            S_PUSH1: begin
                if (r_hi == '0) begin
                    heap_we = 1'b1;
                    heap_wa = '0;
                    heap_wd = r_item;
                    n_state = r_ret;
                end else begin
                    heap_re = 1'b1;
                    heap_ra = (r_hi - HA'(1)) >> 1;
                    n_s     = (r_hi - HA'(1)) >> 1;
                    n_state = S_PUSH2;
                end
            end
            S_PUSH2: begin
                heap_we = 1'b1;
                heap_wa = r_hi;
                if (r_item < heap_rd) begin
                    heap_wd = heap_rd;
                    n_hi    = r_s;
                    n_state = S_PUSH1;
                end else begin
                    heap_wd = r_item;
                    n_state = r_ret;
                end
            end
            S_TR0: begin
                if (r_knone || r_n >= CNT_W'(CELLS)) begin
                    n_len   = r_n;
                    n_state = S_FIN;
                end else begin
                    grid_re = 1'b1;
                    grid_ra = r_k;
                    srch_re = 1'b1;
                    srch_ra = r_k;
                    n_state = S_TR1;
                end
            end
            S_TR1: begin
                // The path list holds goal to start; reads index it from the end.
                n_cost  = r_cost + GB'(g_wt);
                path_we = 1'b1;
                path_wa = CA'(r_n);
                n_n     = r_n + CNT_W'(1);
                n_k     = s_parent;
                n_knone = s_pnone;
                n_state = S_TR0;
            end
            S_RD: begin
                n_valid = 1'b1;
                if (r_rdhit) begin
                    n_crow = gasp_pkg::POS_W'(rd_cell[CA-1:CB]);
                    n_ccol = gasp_pkg::POS_W'(rd_cell[CB-1:0]);
                end else begin
                    n_crow = '0;
                    n_ccol = '0;
                end
                n_state = S_IDLE;
            end
            S_FIN: begin
                n_valid = 1'b1;
                n_crow  = '0;
                n_ccol  = '0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RSTCLR;
            r_ret   <= S_POP0;
            r_cnt   <= '0;
            r_rows  <= gasp_pkg::CFG_W'(32);
            r_cols  <= gasp_pkg::CFG_W'(32);
            r_valid <= 1'b0;
            r_found <= 1'b0;
            r_ovf   <= 1'b0;
            r_cost  <= '0;
            r_len   <= '0;
            r_vis   <= '0;
            r_hsize <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_cnt   <= n_cnt;
            r_rows  <= n_rows;
            r_cols  <= n_cols;
            r_valid <= n_valid;
            r_found <= n_found;
            r_ovf   <= n_ovf;
            r_cost  <= n_cost;
            r_len   <= n_len;
            r_vis   <= n_vis;
            r_hsize <= n_hsize;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nrows  <= n_nrows;
        r_ncols  <= n_ncols;
        r_goal_r <= n_goal_r;
        r_goal_c <= n_goal_c;
        r_item   <= n_item;
        r_top    <= n_top;
        r_last   <= n_last;
        r_hl     <= n_hl;
        r_hs     <= n_hs;
        r_hi     <= n_hi;
        r_s      <= n_s;
        r_dir    <= n_dir;
        r_k      <= n_k;
        r_knone  <= n_knone;
        r_n      <= n_n;
        r_rdhit  <= n_rdhit;
        r_rdpath <= n_rdpath;
        r_crow   <= n_crow;
        r_ccol   <= n_ccol;
    end

    gasp_ram #(.W(GW), .D(1 << CA), .AW(CA)) u_grid_mem (
        .i_clk(i_clk), .i_we(grid_we), .i_wa(grid_wa), .i_wd(grid_wd),
        .i_re(grid_re), .i_ra(grid_ra), .o_rd(grid_rd)
    );

    gasp_ram #(.W(SW), .D(1 << CA), .AW(CA)) u_srch_mem (
        .i_clk(i_clk), .i_we(srch_we), .i_wa(srch_wa), .i_wd(srch_wd),
        .i_re(srch_re), .i_ra(srch_ra), .o_rd(srch_rd)
    );

    gasp_ram #(.W(KW), .D(HEAP_DEPTH), .AW(HA)) u_heap_mem (
        .i_clk(i_clk), .i_we(heap_we), .i_wa(heap_wa), .i_wd(heap_wd),
        .i_re(heap_re), .i_ra(heap_ra), .o_rd(heap_rd)
    );

    gasp_ram #(.W(CA), .D(1 << CA), .AW(CA)) u_vis_mem (
        .i_clk(i_clk), .i_we(vis_we), .i_wa(vis_wa), .i_wd(r_top[CA-1:0]),
        .i_re(vis_re), .i_ra(vis_ra), .o_rd(vis_rd)
    );

    gasp_ram #(.W(CA), .D(1 << CA), .AW(CA)) u_path_mem (
        .i_clk(i_clk), .i_we(path_we), .i_wa(path_wa), .i_wd(r_k),
        .i_re(path_re), .i_ra(path_ra), .o_rd(path_rd)
    );

    assign o_valid         = r_valid;
    assign o_found         = r_found;
    assign o_total_cost    = gasp_pkg::COST_W'(r_cost);
    assign o_path_length   = gasp_pkg::COUNT_W'(r_len);
    assign o_visited_count = gasp_pkg::COUNT_W'(r_vis);
    assign o_cell_row      = r_crow;
    assign o_cell_col      = r_ccol;
    assign o_heap_overflow = r_ovf;

endmodule
